@@ hw/rtl/cbpg_pkg.sv @@
// Colour-bar generator package: item types, register indexes, band colours.
// Used by cbpg_dims, cbpg_eval and color_bar_pattern_generator.
package cbpg_pkg;

    localparam int COORD_W  = 12;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SAMPLE_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd720;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // settle count loaded at reset and on every register write; busy stays high until it runs out
    localparam int SETTLE_CYCLES = 5;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    localparam logic [SAMPLE_W-1:0] Y_BLACK   = 8'd16;
    localparam logic [SAMPLE_W-1:0] Y_WHITE   = 8'd235;
    localparam logic [SAMPLE_W-1:0] Y_ZERO    = 8'd0;
    localparam logic [SAMPLE_W-1:0] Y_PLUGE_LO = 8'd8;
    localparam logic [SAMPLE_W-1:0] Y_PLUGE_HI = 8'd24;
    localparam logic [SAMPLE_W-1:0] C_NEUTRAL = 8'd128;
    localparam logic [SAMPLE_W-1:0] C_LOW     = 8'd16;
    localparam logic [SAMPLE_W-1:0] C_HIGH    = 8'd240;

    typedef logic [2:0] t_bar_idx;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_cbpg_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] blue_diff;
        logic [SAMPLE_W-1:0] red_diff;
    } t_cbpg_out;

    function automatic t_cbpg_out pix(input int y, input int cb, input int cr);
        t_cbpg_out v;
        v.luma      = SAMPLE_W'(y);
        v.blue_diff = SAMPLE_W'(cb);
        v.red_diff  = SAMPLE_W'(cr);
        return v;
    endfunction

    // 75% bars led by 100% white
    function automatic t_cbpg_out top_bar(input t_bar_idx idx);
        t_cbpg_out v;
        case (idx)
            3'd0: v = pix(235, 128, 128);
            3'd1: v = pix(161, 44, 142);
            3'd2: v = pix(131, 156, 44);
            3'd3: v = pix(112, 72, 58);
            3'd4: v = pix(84, 184, 198);
            3'd5: v = pix(65, 100, 212);
            default: v = pix(35, 212, 114);
        endcase
        return v;
    endfunction

    // reversed bars with black in between
    function automatic t_cbpg_out mid_bar(input t_bar_idx idx);
        t_cbpg_out v;
        case (idx)
            3'd0: v = pix(35, 212, 114);
            3'd2: v = pix(84, 184, 198);
            3'd4: v = pix(131, 156, 44);
            3'd6: v = pix(180, 128, 128);
            default: v = pix(16, 128, 128);
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/color_bar_pattern_generator.sv @@
// Colour-bar test pattern generator: one Y'CbCr pixel per accepted position.
// Pixel rate is one item per clock while busy is low; the result strobe is
// registered via r_vld and r_strobe after the edge at which start is taken.
// busy is high after reset and after every register write while the stripe
// and band limits are rederived in the frame-size pipeline; otherwise it stays
// low. The strobe is high for one cycle and the receiver cannot stall it.
// Depends on cbpg_pkg, cbpg_dims and cbpg_eval.
module color_bar_pattern_generator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cbpg_pkg::t_cbpg_in             i_item,
    output logic                           o_strobe,
    output cbpg_pkg::t_cbpg_out            o_result,
    input  logic                           i_cfg_we,
    input  logic [cbpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbpg_pkg::CFG_W-1:0]     i_cfg_data
);
    import cbpg_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [SETTLE_W-1:0]   r_settle, n_settle;
    logic                  accept;
    logic [5:0][DIM_W:0]   bound;
    logic [DIM_W:0]        p1, p2, p3, t1, t2;
    logic [DIM_W-1:0]      h23, h34;

    assign busy   = (r_settle != '0);
    assign accept = start && !busy;

    always_comb begin
        if (i_cfg_we) begin
            n_settle = SETTLE_W'(SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            n_settle = r_settle - SETTLE_W'(1);
        end else begin
            n_settle = r_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            r_settle <= n_settle;
        end
    end

    cbpg_dims #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_dims (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_bound    (bound),
        .o_p1       (p1),
        .o_p2       (p2),
        .o_p3       (p3),
        .o_t1       (t1),
        .o_t2       (t2),
        .o_h23      (h23),
        .o_h34      (h34)
    );

    cbpg_eval #(
        .DIM_W (DIM_W)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_bound  (bound),
        .i_p1     (p1),
        .i_p2     (p2),
        .i_p3     (p3),
        .i_t1     (t1),
        .i_t2     (t2),
        .i_h23    (h23),
        .i_h34    (h34),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy not raised after register write");

    a_item_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("item result missing two cycles after accept");

    a_pluge_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.luma == Y_PLUGE_LO) |->
            (o_result.blue_diff == C_NEUTRAL && o_result.red_diff == C_NEUTRAL))
        else $error("PLUGE sample carries chroma");

endmodule

@@ hw/rtl/cbpg_dims.sv @@
// Frame-size registers and the pipeline that derives stripe and band limits.
// Depends on cbpg_pkg.
module cbpg_dims #(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbpg_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [5:0][DIM_W:0]            o_bound,
    output logic [DIM_W:0]                 o_p1,
    output logic [DIM_W:0]                 o_p2,
    output logic [DIM_W:0]                 o_p3,
    output logic [DIM_W:0]                 o_t1,
    output logic [DIM_W:0]                 o_t2,
    output logic [DIM_W-1:0]               o_h23,
    output logic [DIM_W-1:0]               o_h34
);
    import cbpg_pkg::*;

    localparam int BW  = DIM_W + 1;
    localparam int XW  = DIM_W + 1;
    localparam int LW  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int M7  = (2 ** XW) / 7;
    localparam int M3H = (2 ** XW) / 3;
    localparam int M3S = (2 ** DIM_W) / 3;

    logic [CFG_W-1:0] r_width, r_height;

    // stage 1: clamp
    logic [LW-1:0]    wl, hl;
    logic [DIM_W-1:0] n_wc, n_hc, r_wc, r_hc;
    // stage 2: reciprocal estimates
    logic [XW-1:0]    sx, hx;
    logic [2*XW-1:0]  prod_s, prod_h;
    logic [DIM_W+1:0] h3;
    logic [XW-1:0]    r_sx, r_sq, r_hx, r_hq;
    logic [DIM_W-1:0] r_h34;
    // stage 3: corrections
    logic [XW-1:0]    rem_s, rem_h;
    logic [DIM_W-1:0] r_s, r_h23;
    // stage 4: multiples of the stripe width
    logic [2*DIM_W-1:0] prod_s3;
    logic [DIM_W+2:0]   s5;
    logic [DIM_W-1:0]   r_s3q, r_s4;
    logic [5:0][BW-1:0] r_bound;
    logic [BW-1:0]      r_p1;
    // stage 5
    logic [DIM_W-1:0] rem_s3;
    logic [DIM_W-1:0] r_s3;
    logic [BW-1:0]    r_p2, r_p3;
    // stage 6
    logic [BW-1:0]    r_t1, r_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        wl = LW'(r_width);
        hl = LW'(r_height);
        if (wl > LW'(MAX_DIM)) begin
            n_wc = DIM_W'(MAX_DIM);
        end else if (wl == '0) begin
            n_wc = DIM_W'(1);
        end else begin
            n_wc = DIM_W'(wl);
        end
        if (hl > LW'(MAX_DIM)) begin
            n_hc = DIM_W'(MAX_DIM);
        end else begin
            n_hc = DIM_W'(hl);
        end
    end

    assign sx     = XW'(r_wc) + XW'(6);
    assign hx     = {r_hc, 1'b0};
    assign prod_s = (2*XW)'(sx) * (2*XW)'(M7);
    assign prod_h = (2*XW)'(hx) * (2*XW)'(M3H);
    assign h3     = (DIM_W+2)'(r_hc) + (DIM_W+2)'({r_hc, 1'b0});

    assign rem_s = r_sx - XW'(r_sq * 7);
    assign rem_h = r_hx - XW'(r_hq * 3);

    assign prod_s3 = (2*DIM_W)'(r_s) * (2*DIM_W)'(M3S);
    assign s5      = (DIM_W+3)'(r_s) + (DIM_W+3)'({r_s, 2'b00});

    assign rem_s3 = r_s4 - DIM_W'(r_s3q * 3);

    always_ff @(posedge i_clk) begin
        r_wc  <= n_wc;
        r_hc  <= n_hc;

        r_sx  <= sx;
        r_sq  <= prod_s[2*XW-1:XW];
        r_hx  <= hx;
        r_hq  <= prod_h[2*XW-1:XW];
        r_h34 <= h3[DIM_W+1:2];

        r_s   <= DIM_W'(r_sq + XW'(rem_s >= XW'(7)));
        r_h23 <= DIM_W'(r_hq + XW'(rem_h >= XW'(3)));

        r_s3q <= prod_s3[2*DIM_W-1:DIM_W];
        r_s4  <= r_s;
        for (int k = 0; k < 6; k++) begin
            r_bound[k] <= BW'(r_s * (k + 1));
        end
        r_p1  <= s5[DIM_W+2:2];

        r_s3  <= r_s3q + DIM_W'(rem_s3 >= DIM_W'(3));
        r_p2  <= {r_p1[BW-2:0], 1'b0};
        r_p3  <= r_p1 + {r_p1[BW-2:0], 1'b0};

        r_t1  <= r_bound[4] + BW'(r_s3);
        r_t2  <= r_bound[4] + BW'({r_s3, 1'b0});
    end

    assign o_bound = r_bound;
    assign o_p1    = r_p1;
    assign o_p2    = r_p2;
    assign o_p3    = r_p3;
    assign o_t1    = r_t1;
    assign o_t2    = r_t2;
    assign o_h23   = r_h23;
    assign o_h34   = r_h34;

endmodule

@@ hw/rtl/cbpg_eval.sv @@
// Per-pixel evaluation: input register, band and stripe decode, result register.
// Depends on cbpg_pkg.
module cbpg_eval #(
    parameter int DIM_W = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  cbpg_pkg::t_cbpg_in   i_item,
    input  logic [5:0][DIM_W:0]  i_bound,
    input  logic [DIM_W:0]       i_p1,
    input  logic [DIM_W:0]       i_p2,
    input  logic [DIM_W:0]       i_p3,
    input  logic [DIM_W:0]       i_t1,
    input  logic [DIM_W:0]       i_t2,
    input  logic [DIM_W-1:0]     i_h23,
    input  logic [DIM_W-1:0]     i_h34,
    output logic                 o_strobe,
    output cbpg_pkg::t_cbpg_out  o_result
);
    import cbpg_pkg::*;

    localparam int BW    = DIM_W + 1;
    localparam int CMP_W = (BW > COORD_W) ? BW : COORD_W;

    logic      r_vld, r_strobe;
    t_cbpg_in  r_item;
    t_cbpg_out n_result, r_result;
    logic [CMP_W-1:0] col_x, row_x;
    t_bar_idx  idx;

    assign col_x = CMP_W'(r_item.column);
    assign row_x = CMP_W'(r_item.row);

    always_comb begin
        idx = '0;
        for (int k = 0; k < 6; k++) begin
            if (col_x >= CMP_W'(i_bound[k])) begin
                idx = idx + t_bar_idx'(1);
            end
        end

        n_result = pix(16, 128, 128);
        if (row_x < CMP_W'(i_h23)) begin
            n_result = top_bar(idx);
        end else if (row_x < CMP_W'(i_h34)) begin
            n_result = mid_bar(idx);
        end else if (col_x < CMP_W'(i_p1)) begin
            n_result.luma      = Y_ZERO;
            n_result.blue_diff = C_LOW;
        end else if (col_x < CMP_W'(i_p2)) begin
            n_result.luma = Y_WHITE;
        end else if (col_x < CMP_W'(i_p3)) begin
            n_result.luma     = Y_ZERO;
            n_result.red_diff = C_HIGH;
        end else if (col_x < CMP_W'(i_bound[4])) begin
            n_result.luma = Y_BLACK;
        end else if (col_x < CMP_W'(i_t1)) begin
            n_result.luma = Y_PLUGE_LO;
        end else if (col_x < CMP_W'(i_t2)) begin
            n_result.luma = Y_BLACK;
        end else if (col_x < CMP_W'(i_bound[5])) begin
            n_result.luma = Y_PLUGE_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= i_accept;
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for color_bar_pattern_generator: directed probes, then random pixels.
// Pixels not typed in are predicted by a local bar-layout model under the mirrored frame size.
// Depends on cbpg_pkg and the generator RTL.
`timescale 1ns / 100ps

module testbench;
    import cbpg_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 80;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit                 known;
        t_cbpg_out          val;
    } t_probe;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_cbpg_in             i_item = '0;
    logic                 o_strobe;
    t_cbpg_out            o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // typed-in expectation travelling alongside the item
    bit        note_known = 1'b0;
    t_cbpg_out note_val = '0;

    logic [CFG_W-1:0] frame_w = WIDTH_RESET;
    logic [CFG_W-1:0] frame_h = HEIGHT_RESET;
    t_cbpg_out        pixels_due[$];
    t_probe           probes[$];
    int               fail_count = 0;
    int               cycle_count = 0;
    bit               calm = 1'b0;

    color_bar_pattern_generator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_cbpg_out ycc(input int y, input int cb, input int cr);
        t_cbpg_out v;
        v.luma      = y[7:0];
        v.blue_diff = cb[7:0];
        v.red_diff  = cr[7:0];
        return v;
    endfunction

    function automatic int unsigned clip_dim(input logic [CFG_W-1:0] v);
        return (v > CFG_W'(MAX_DIM)) ? MAX_DIM : 32'(v);
    endfunction

    function automatic t_cbpg_out bar_pixel(input logic [COORD_W-1:0] col,
                                            input logic [COORD_W-1:0] row,
                                            input logic [CFG_W-1:0] fw,
                                            input logic [CFG_W-1:0] fh);
        int unsigned w, h, s, idx, p, c, r;
        t_cbpg_out   px;
        w = clip_dim(fw);
        h = clip_dim(fh);
        if (w == 0) w = 1;
        c = 32'(col);
        r = 32'(row);
        s = (w + 6) / 7;
        idx = c / s;
        if (idx > 6) idx = 6;
        px = ycc(16, 128, 128);
        if (r < h * 2 / 3) begin
            case (idx)
                0: px = ycc(235, 128, 128);
                1: px = ycc(161, 44, 142);
                2: px = ycc(131, 156, 44);
                3: px = ycc(112, 72, 58);
                4: px = ycc(84, 184, 198);
                5: px = ycc(65, 100, 212);
                default: px = ycc(35, 212, 114);
            endcase
        end else if (r < h * 3 / 4) begin
            case (idx)
                0: px = ycc(35, 212, 114);
                2: px = ycc(84, 184, 198);
                4: px = ycc(131, 156, 44);
                6: px = ycc(180, 128, 128);
                default: px = ycc(16, 128, 128);
            endcase
        end else begin
            p = 5 * s / 4;
            if (c < p) px = ycc(0, 16, 128);
            else if (c < 2 * p) px = ycc(235, 128, 128);
            else if (c < 3 * p) px = ycc(0, 128, 240);
            else if (c < 5 * s) px = ycc(16, 128, 128);
            else if (c < 5 * s + s / 3) px = ycc(8, 128, 128);
            else if (c < 5 * s + 2 * (s / 3)) px = ycc(16, 128, 128);
            else if (c < 6 * s) px = ycc(24, 128, 128);
            else px = ycc(16, 128, 128);
        end
        return px;
    endfunction

    // acceptance, register mirror and result checking in one ordered process
    always @(posedge i_clk) begin : watch
        t_cbpg_out want;
        cycle_count++;
        if (!i_rst_n) begin
            frame_w = WIDTH_RESET;
            frame_h = HEIGHT_RESET;
        end else begin
            if (start && !busy)
                pixels_due.push_back(note_known ? note_val :
                                     bar_pixel(i_item.column, i_item.row, frame_w, frame_h));
            if (o_strobe) begin
                if (pixels_due.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    fail_count++;
                end else begin
                    want = pixels_due.pop_front();
                    if (o_result.luma !== want.luma) begin
                        $error("luma: expected %0d, got %0d", want.luma, o_result.luma);
                        fail_count++;
                    end
                    if (o_result.blue_diff !== want.blue_diff) begin
                        $error("blue_diff: expected %0d, got %0d",
                               want.blue_diff, o_result.blue_diff);
                        fail_count++;
                    end
                    if (o_result.red_diff !== want.red_diff) begin
                        $error("red_diff: expected %0d, got %0d",
                               want.red_diff, o_result.red_diff);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  frame_w = i_cfg_data;
                    REG_FRAME_HEIGHT: frame_h = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drive_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                               input bit known, input t_cbpg_out val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_item     <= {col, row};
        note_known <= known;
        note_val   <= val;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // drop start and wait for every outstanding pixel
    task automatic drain;
        start <= 1'b0;
        wait (pixels_due.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= REG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_probe(input int col, input int row, input bit known,
                             input int y, input int cb, input int cr);
        t_probe pr;
        pr.col   = col[COORD_W-1:0];
        pr.row   = row[COORD_W-1:0];
        pr.known = known;
        pr.val   = ycc(y, cb, cr);
        probes.push_back(pr);
    endtask

    initial begin : stimulus
        int unsigned w, h, wspan, hspan, pick;
        logic [COORD_W-1:0] col, row;
        logic [CFG_W-1:0] pw, ph;

        // reset frame 720x480: stripe 103, band edges at rows 320 and 360
        add_probe(0, 0, 1, 235, 128, 128);
        add_probe(102, 0, 1, 235, 128, 128);
        add_probe(103, 0, 1, 161, 44, 142);
        add_probe(4095, 0, 1, 35, 212, 114);
        add_probe(400, 200, 0, 0, 0, 0);
        add_probe(719, 319, 0, 0, 0, 0);
        add_probe(0, 320, 1, 35, 212, 114);
        add_probe(103, 320, 1, 16, 128, 128);
        add_probe(719, 359, 1, 180, 128, 128);
        add_probe(4095, 340, 1, 180, 128, 128);
        add_probe(0, 360, 1, 0, 16, 128);
        add_probe(127, 360, 1, 0, 16, 128);
        add_probe(128, 360, 1, 235, 128, 128);
        add_probe(256, 400, 1, 0, 128, 240);
        add_probe(384, 479, 0, 0, 0, 0);
        add_probe(515, 479, 0, 0, 0, 0);
        add_probe(549, 479, 0, 0, 0, 0);
        add_probe(583, 479, 0, 0, 0, 0);
        add_probe(617, 479, 0, 0, 0, 0);
        add_probe(618, 479, 0, 0, 0, 0);
        add_probe(0, 4095, 1, 0, 16, 128);
        add_probe(4095, 4095, 1, 16, 128, 128);
        add_probe(2730, 1365, 0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k])
            drive_pixel(probes[k].col, probes[k].row, probes[k].known, probes[k].val);
        drain();

        for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
            case (ph_i)
                0: begin pw = 13'd1;    ph = 13'd1;    end
                1: begin pw = 13'd4096; ph = 13'd4096; end
                2: begin pw = 13'd0;    ph = 13'd0;    end
                3: begin pw = 13'd8191; ph = 13'd8191; end
                4: begin pw = 13'd4097; ph = 13'd3;    end
                5: begin pw = 13'd7;    ph = 13'd2;    end
                6: begin pw = 13'd13;   ph = 13'd4000; end
                7: begin pw = 13'd720;  ph = 13'd480;  end
                default: begin
                    pw = CFG_W'($urandom_range(1, 4096));
                    ph = CFG_W'($urandom_range(1, 4096));
                end
            endcase
            set_frame(pw, ph);
            w = clip_dim(pw);
            h = clip_dim(ph);
            wspan = (w == 0) ? 1 : w;
            hspan = (h == 0) ? 1 : h;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                col = COORD_W'($urandom_range(0, wspan - 1));
                row = COORD_W'($urandom_range(0, hspan - 1));
                if (pick < 15) begin
                    col = COORD_W'($urandom);
                    row = COORD_W'($urandom);
                end else if (pick < 30) begin
                    case ($urandom_range(0, 3))
                        0: row = COORD_W'((h * 2 / 3 == 0) ? 0 : h * 2 / 3 - 1);
                        1: row = COORD_W'(h * 2 / 3);
                        2: row = COORD_W'((h * 3 / 4 == 0) ? 0 : h * 3 / 4 - 1);
                        default: row = COORD_W'(h * 3 / 4);
                    endcase
                end
                drive_pixel(col, row, 1'b0, '0);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pixels_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cbpg_pkg.sv
hw/rtl/cbpg_dims.sv
hw/rtl/cbpg_eval.sv
hw/rtl/color_bar_pattern_generator.sv
sim/testbench.sv
